>>> rtl/core/cau_pkg.sv
// Shared types and opcodes for the complex arithmetic unit.
package cau_pkg;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    div_zero;
   } ctrl_type;

   localparam int CtrlWidth = $bits(ctrl_type);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> rtl/core/cau_front.sv
// Front end: takes a command transfer, classifies it and hands it to the queue.
module cau_front #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   input  cau_pkg::queue_stat_type      q_stat,
   output logic                         push,
   output cau_pkg::ctrl_type            item_ctrl,
   output logic signed [DATA_WIDTH-1:0] item_a_re,
   output logic signed [DATA_WIDTH-1:0] item_a_im,
   output logic signed [DATA_WIDTH-1:0] item_b_re,
   output logic signed [DATA_WIDTH-1:0] item_b_im
);
   import cau_pkg::*;

   logic     valid_ff, valid_in;
   logic     accept;
   ctrl_type ctrl_ff, ctrl_in;
   logic signed [DATA_WIDTH-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;

   assign busy   = valid_ff && q_stat.full;
   assign accept = start && !busy;
   assign push   = valid_ff && !q_stat.full;

   always_comb begin
      ctrl_in.cmd      = cmd_type'(req_cmd);
      ctrl_in.div_zero = (cmd_type'(req_cmd) == CMD_DIV) && (req_b_re == '0) && (req_b_im == '0);
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl_in;
         a_re_ff <= req_a_re;
         a_im_ff <= req_a_im;
         b_re_ff <= req_b_re;
         b_im_ff <= req_b_im;
      end
   end

   assign item_ctrl = ctrl_ff;
   assign item_a_re = a_re_ff;
   assign item_a_im = a_im_ff;
   assign item_b_re = b_re_ff;
   assign item_b_im = b_im_ff;

endmodule

>>> rtl/core/cau_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
module cau_queue #(
   parameter int WIDTH = 67
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output cau_pkg::queue_stat_type stat
);
   import cau_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/cau_back.sv
// Back end: products, sums, rounding, pipelined restoring divider and saturation.
module cau_back #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  cau_pkg::ctrl_type            in_ctrl,
   input  logic signed [DATA_WIDTH-1:0] in_a_re,
   input  logic signed [DATA_WIDTH-1:0] in_a_im,
   input  logic signed [DATA_WIDTH-1:0] in_b_re,
   input  logic signed [DATA_WIDTH-1:0] in_b_im,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_overflow,
   output logic                         rsp_div_zero
);
   import cau_pkg::*;

   localparam int W       = DATA_WIDTH;
   localparam int PW      = 2 * W;
   localparam int SW      = 2 * W + 1;
   localparam int K       = W + 2;
   localparam int MW      = SW;
   localparam int RW      = SW + FRAC_BITS + 1 + K;
   localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

   function automatic logic [W:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] lim_neg;
      logic [MW-1:0] lim_pos;
      logic [MW-1:0] m;
      logic          ov;
      lim_neg = MW'(1) << (W - 1);
      lim_pos = lim_neg - MW'(1);
      m       = mag;
      ov      = 1'b0;
      if (neg) begin
         if (m > lim_neg) begin
            m  = lim_neg;
            ov = 1'b1;
         end
         m = MW'(0) - m;
      end else if (m > lim_pos) begin
         m  = lim_pos;
         ov = 1'b1;
      end
      return {ov, m[W-1:0]};
   endfunction

   // stage 0: products and add/sub
   logic                 s0_valid_ff;
   ctrl_type             s0_ctrl_ff;
   logic signed [W:0]    s0_sum_re_ff, s0_sum_im_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bbr_ff, p_bbi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s0_ctrl_ff <= in_ctrl;
      if (in_ctrl.cmd == CMD_SUB) begin
         s0_sum_re_ff <= (W+1)'(in_a_re) - (W+1)'(in_b_re);
         s0_sum_im_ff <= (W+1)'(in_a_im) - (W+1)'(in_b_im);
      end else begin
         s0_sum_re_ff <= (W+1)'(in_a_re) + (W+1)'(in_b_re);
         s0_sum_im_ff <= (W+1)'(in_a_im) + (W+1)'(in_b_im);
      end
      p_rr_ff  <= PW'(in_a_re) * PW'(in_b_re);
      p_ii_ff  <= PW'(in_a_im) * PW'(in_b_im);
      p_ri_ff  <= PW'(in_a_re) * PW'(in_b_im);
      p_ir_ff  <= PW'(in_a_im) * PW'(in_b_re);
      p_bbr_ff <= PW'(in_b_re) * PW'(in_b_re);
      p_bbi_ff <= PW'(in_b_im) * PW'(in_b_im);
   end

   // stage 1: cross sums
   logic                 s1_valid_ff;
   ctrl_type             s1_ctrl_ff;
   logic signed [W:0]    s1_sum_re_ff, s1_sum_im_ff;
   logic signed [SW-1:0] m_re_ff, m_im_ff, n_re_ff, n_im_ff;
   logic [PW-1:0]        den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff   <= s0_ctrl_ff;
      s1_sum_re_ff <= s0_sum_re_ff;
      s1_sum_im_ff <= s0_sum_im_ff;
      m_re_ff      <= SW'(p_rr_ff) - SW'(p_ii_ff);
      m_im_ff      <= SW'(p_ri_ff) + SW'(p_ir_ff);
      n_re_ff      <= SW'(p_rr_ff) + SW'(p_ii_ff);
      n_im_ff      <= SW'(p_ir_ff) - SW'(p_ri_ff);
      den_ff       <= $unsigned(p_bbr_ff) + $unsigned(p_bbi_ff);
   end

   // stage 2: non-divide results and divider set-up
   logic [MW-1:0]   half;
   logic            as_neg_re, as_neg_im, mu_neg_re, mu_neg_im, nd_neg_re, nd_neg_im;
   logic [W:0]      as_mag_re, as_mag_im;
   logic [SW-1:0]   mu_mag_re, mu_mag_im, nd_mag_re, nd_mag_im;
   logic [MW:0]     mu_rnd_re, mu_rnd_im;
   logic [W:0]      sat_re, sat_im;
   logic [RW-1:0]   x_re, x_im, den_top;

   // divider pipeline, entry 0 loaded from stage 2
   logic            dv_valid_ff [K+1];
   ctrl_type        dv_ctrl_ff  [K+1];
   logic            dv_neg_re_ff [K+1], dv_neg_im_ff [K+1];
   logic            dv_big_re_ff [K+1], dv_big_im_ff [K+1];
   logic [PW-1:0]   dv_den_ff [K+1];
   logic [RW-1:0]   dv_rem_re_ff [K+1], dv_rem_im_ff [K+1];
   logic [K-1:0]    dv_q_re_ff [K+1], dv_q_im_ff [K+1];
   logic [W-1:0]    dv_r_re_ff [K+1], dv_r_im_ff [K+1];
   logic            dv_ov_ff [K+1];

   always_comb begin
      half      = (FRAC_BITS > 0) ? (MW'(1) << HALF_SH) : '0;
      as_neg_re = s1_sum_re_ff[W];
      as_neg_im = s1_sum_im_ff[W];
      as_mag_re = $unsigned(as_neg_re ? -s1_sum_re_ff : s1_sum_re_ff);
      as_mag_im = $unsigned(as_neg_im ? -s1_sum_im_ff : s1_sum_im_ff);
      mu_neg_re = m_re_ff[SW-1];
      mu_neg_im = m_im_ff[SW-1];
      mu_mag_re = $unsigned(mu_neg_re ? -m_re_ff : m_re_ff);
      mu_mag_im = $unsigned(mu_neg_im ? -m_im_ff : m_im_ff);
      mu_rnd_re = ((MW+1)'(mu_mag_re) + (MW+1)'(half)) >> FRAC_BITS;
      mu_rnd_im = ((MW+1)'(mu_mag_im) + (MW+1)'(half)) >> FRAC_BITS;
      if (s1_ctrl_ff.cmd == CMD_ADD || s1_ctrl_ff.cmd == CMD_SUB) begin
         sat_re = sat_mag(as_neg_re, MW'(as_mag_re));
         sat_im = sat_mag(as_neg_im, MW'(as_mag_im));
      end else begin
         sat_re = sat_mag(mu_neg_re, mu_rnd_re[MW-1:0]);
         sat_im = sat_mag(mu_neg_im, mu_rnd_im[MW-1:0]);
      end
      nd_neg_re = n_re_ff[SW-1];
      nd_neg_im = n_im_ff[SW-1];
      nd_mag_re = $unsigned(nd_neg_re ? -n_re_ff : n_re_ff);
      nd_mag_im = $unsigned(nd_neg_im ? -n_im_ff : n_im_ff);
      x_re      = RW'(nd_mag_re) << (FRAC_BITS + 1);
      x_im      = RW'(nd_mag_im) << (FRAC_BITS + 1);
      den_top   = RW'(den_ff) << K;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_ctrl_ff[0]   <= s1_ctrl_ff;
      dv_neg_re_ff[0] <= nd_neg_re;
      dv_neg_im_ff[0] <= nd_neg_im;
      dv_big_re_ff[0] <= (x_re >= den_top);
      dv_big_im_ff[0] <= (x_im >= den_top);
      dv_den_ff[0]    <= den_ff;
      dv_rem_re_ff[0] <= x_re;
      dv_rem_im_ff[0] <= x_im;
      dv_q_re_ff[0]   <= '0;
      dv_q_im_ff[0]   <= '0;
      dv_r_re_ff[0]   <= sat_re[W-1:0];
      dv_r_im_ff[0]   <= sat_im[W-1:0];
      dv_ov_ff[0]     <= sat_re[W] | sat_im[W];
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < K; j++) begin : g_div
      logic [RW-1:0] trial;
      logic          take_re, take_im;
      logic [RW-1:0] rem_re_in, rem_im_in;
      logic [K-1:0]  q_re_in, q_im_in;

      always_comb begin
         trial     = RW'(dv_den_ff[j]) << (K - 1 - j);
         take_re   = (dv_rem_re_ff[j] >= trial);
         take_im   = (dv_rem_im_ff[j] >= trial);
         rem_re_in = take_re ? dv_rem_re_ff[j] - trial : dv_rem_re_ff[j];
         rem_im_in = take_im ? dv_rem_im_ff[j] - trial : dv_rem_im_ff[j];
         q_re_in   = dv_q_re_ff[j] | (K'(take_re) << (K - 1 - j));
         q_im_in   = dv_q_im_ff[j] | (K'(take_im) << (K - 1 - j));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         dv_ctrl_ff[j+1]   <= dv_ctrl_ff[j];
         dv_neg_re_ff[j+1] <= dv_neg_re_ff[j];
         dv_neg_im_ff[j+1] <= dv_neg_im_ff[j];
         dv_big_re_ff[j+1] <= dv_big_re_ff[j];
         dv_big_im_ff[j+1] <= dv_big_im_ff[j];
         dv_den_ff[j+1]    <= dv_den_ff[j];
         dv_rem_re_ff[j+1] <= rem_re_in;
         dv_rem_im_ff[j+1] <= rem_im_in;
         dv_q_re_ff[j+1]   <= q_re_in;
         dv_q_im_ff[j+1]   <= q_im_in;
         dv_r_re_ff[j+1]   <= dv_r_re_ff[j];
         dv_r_im_ff[j+1]   <= dv_r_im_ff[j];
         dv_ov_ff[j+1]     <= dv_ov_ff[j];
      end
   end

   // final stage: round the quotient, saturate, select
   logic [K:0]     q_sum_re, q_sum_im;
   logic [W:0]     dsat_re, dsat_im;
   logic           out_valid_ff;
   logic [W-1:0]   out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic           out_ov_ff, out_dz_ff, out_ov_in, out_dz_in;

   always_comb begin
      q_sum_re = (K+1)'(dv_q_re_ff[K]) + (K+1)'(1);
      q_sum_im = (K+1)'(dv_q_im_ff[K]) + (K+1)'(1);
      dsat_re  = sat_mag(dv_neg_re_ff[K],
                         dv_big_re_ff[K] ? '1 : MW'(q_sum_re[K:1]));
      dsat_im  = sat_mag(dv_neg_im_ff[K],
                         dv_big_im_ff[K] ? '1 : MW'(q_sum_im[K:1]));
      priority if (dv_ctrl_ff[K].cmd == CMD_DIV && dv_ctrl_ff[K].div_zero) begin
         out_re_in = '0;
         out_im_in = '0;
         out_ov_in = 1'b0;
         out_dz_in = 1'b1;
      end else if (dv_ctrl_ff[K].cmd == CMD_DIV) begin
         out_re_in = dsat_re[W-1:0];
         out_im_in = dsat_im[W-1:0];
         out_ov_in = dsat_re[W] | dsat_im[W];
         out_dz_in = 1'b0;
      end else begin
         out_re_in = dv_r_re_ff[K];
         out_im_in = dv_r_im_ff[K];
         out_ov_in = dv_ov_ff[K];
         out_dz_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[K];
      end
   end

   always_ff @(posedge clock) begin
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
      out_ov_ff <= out_ov_in;
      out_dz_ff <= out_dz_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_re   = $signed(out_re_ff);
   assign rsp_res_im   = $signed(out_im_ff);
   assign rsp_overflow = out_ov_ff;
   assign rsp_div_zero = out_dz_ff;

endmodule

>>> rtl/core/complex_arith_unit_core.sv
// Top level of the complex arithmetic unit.
//
// Command channel: an operation is transferred at a rising edge with start high
// and busy low. req_cmd selects add, subtract, multiply or divide on the complex
// operands req_a_* and req_b_*, signed fixed point with FRAC_BITS fraction bits.
// Result channel: rsp_valid is high for exactly one cycle per operation, with
// rsp_res_re, rsp_res_im, rsp_overflow and rsp_div_zero valid in that cycle.
// Results leave in the order the commands came in.
// Every operation takes the same time from the command transfer to the
// rsp_valid cycle, as all of them pass through the divider, a pipeline of
// DATA_WIDTH + 2 restoring stages, one quotient bit per stage.
// Throughput: one operation per cycle; start may be held high continuously.
// A two-entry queue sits between the front end and the arithmetic pipeline.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
// Reset (synchronous, active high) empties the queue and the pipeline; no
// result strobe appears for operations in flight at reset.
module complex_arith_unit_core #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_overflow,
   output logic                         rsp_div_zero
);
   import cau_pkg::*;

   localparam int QW = CtrlWidth + 4 * DATA_WIDTH;

   queue_stat_type               q_stat;
   logic                         push;
   ctrl_type                     item_ctrl;
   logic signed [DATA_WIDTH-1:0] item_a_re, item_a_im, item_b_re, item_b_im;
   logic [QW-1:0]                q_wdata, q_rdata;
   ctrl_type                     head_ctrl;

   cau_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .req_a_re  (req_a_re),
      .req_a_im  (req_a_im),
      .req_b_re  (req_b_re),
      .req_b_im  (req_b_im),
      .q_stat    (q_stat),
      .push      (push),
      .item_ctrl (item_ctrl),
      .item_a_re (item_a_re),
      .item_a_im (item_a_im),
      .item_b_re (item_b_re),
      .item_b_im (item_b_im)
   );

   assign q_wdata = {item_ctrl, item_a_re, item_a_im, item_b_re, item_b_im};

   cau_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_wdata),
      .pop       (!q_stat.empty),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   assign head_ctrl = ctrl_type'(q_rdata[QW-1 -: CtrlWidth]);

   cau_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!q_stat.empty),
      .in_ctrl      (head_ctrl),
      .in_a_re      ($signed(q_rdata[4*DATA_WIDTH-1 -: DATA_WIDTH])),
      .in_a_im      ($signed(q_rdata[3*DATA_WIDTH-1 -: DATA_WIDTH])),
      .in_b_re      ($signed(q_rdata[2*DATA_WIDTH-1 -: DATA_WIDTH])),
      .in_b_im      ($signed(q_rdata[DATA_WIDTH-1 -: DATA_WIDTH])),
      .rsp_valid    (rsp_valid),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_overflow (rsp_overflow),
      .rsp_div_zero (rsp_div_zero)
   );

endmodule
